### hdl/ssaf_pkg.sv
package ssaf_pkg;

  localparam int MAX_DIGITS = 5;
  localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);
  localparam int SEG_IDX_W  = 3;

  localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
  localparam int          DIV10_SHIFT = 19;

  localparam logic [6:0] CH_NL    = 7'h0A;
  localparam logic [6:0] CH_ZERO  = 7'("0");
  localparam logic [6:0] CH_MINUS = 7'("-");

  typedef struct packed {
    logic               kind;
    logic signed [15:0] temperature;
    logic        [7:0]  humidity;
    logic        [15:0] light_level;
  } in_word_t;

  typedef struct packed {
    logic [6:0] text_char;
    logic       frame_end;
  } out_word_t;

  typedef struct packed {
    logic        fail;
    logic        neg;
    logic [15:0] temp_mag;
    logic [7:0]  humidity;
    logic [15:0] light_level;
  } cmd_t;

  typedef enum logic [2:0] {
    SEG_HDR,
    SEG_SEP_H,
    SEG_SEP_L,
    SEG_TAIL,
    SEG_FAIL
  } seg_t;

  function automatic logic [SEG_IDX_W-1:0] seg_last(seg_t s);
    logic [SEG_IDX_W-1:0] n;
    unique case (s)
      SEG_HDR:   n = SEG_IDX_W'(4);
      SEG_SEP_H: n = SEG_IDX_W'(2);
      SEG_SEP_L: n = SEG_IDX_W'(2);
      SEG_TAIL:  n = SEG_IDX_W'(1);
      SEG_FAIL:  n = SEG_IDX_W'(3);
      default:   n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [6:0] seg_char(seg_t s, logic [SEG_IDX_W-1:0] i);
    logic [6:0] c;
    c = CH_NL;
    unique case (s)
      SEG_HDR: begin
        unique case (i)
          3'd0:    c = 7'("<");
          3'd1:    c = 7'("S");
          3'd2:    c = 7'(",");
          3'd3:    c = 7'("T");
          default: c = 7'("=");
        endcase
      end
      SEG_SEP_H: begin
        unique case (i)
          3'd0:    c = 7'(",");
          3'd1:    c = 7'("H");
          default: c = 7'("=");
        endcase
      end
      SEG_SEP_L: begin
        unique case (i)
          3'd0:    c = 7'(",");
          3'd1:    c = 7'("L");
          default: c = 7'("=");
        endcase
      end
      SEG_TAIL: begin
        unique case (i)
          3'd0:    c = 7'(">");
          default: c = CH_NL;
        endcase
      end
      SEG_FAIL: begin
        unique case (i)
          3'd0:    c = 7'("<");
          3'd1:    c = 7'("F");
          3'd2:    c = 7'(">");
          default: c = CH_NL;
        endcase
      end
      default: c = CH_NL;
    endcase
    return c;
  endfunction

endpackage

### hdl/sensor_sample_ascii_framer.sv
// Turns each sensor record into an ASCII frame, one character per output word:
// "<S,T=t,H=h,L=l>\n" for a sample, "<F>\n" for a failed reading, numbers in
// decimal without leading zeros and a '-' ahead of a negative temperature;
// frame_end marks the closing newline. A two-entry queue sits between the input
// classifier and the character sequencer, so up to two records are taken while
// a frame is still being sent. The sequencer emits one character per cycle while
// the output accepts them, and stops emitting to convert each number: one
// divide-by-ten per cycle fills a digit buffer, which it then sends most
// significant digit first. It takes the next record only once back in idle.
module sensor_sample_ascii_framer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ssaf_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output ssaf_pkg::out_word_t out_word
);
  import ssaf_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  ssaf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  ssaf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("sequencer still ready after taking a record");

  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> cmd_valid)
    else $error("accepted record missing from queue");

  a_printable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.text_char >= 7'h20 || out_word.text_char == CH_NL)
    else $error("non-printable character on output");

endmodule

### hdl/ssaf_front.sv
module ssaf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ssaf_pkg::in_word_t in_word,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output ssaf_pkg::cmd_t    cmd
);
  import ssaf_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  cmd_t       cls;
  logic       push;
  logic       pop;
  logic [15:0] t_bits;

  assign t_bits = in_word.temperature;

  always_comb begin
    cls.fail        = in_word.kind;
    cls.neg         = t_bits[15];
    cls.temp_mag    = t_bits[15] ? 16'(~t_bits + 16'd1) : t_bits;
    cls.humidity    = in_word.humidity;
    cls.light_level = in_word.light_level;
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= 2'(cnt_r + {1'b0, push} - {1'b0, pop});
    end
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

### hdl/ssaf_back.sv
module ssaf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  ssaf_pkg::cmd_t     cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output ssaf_pkg::out_word_t out_word
);
  import ssaf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TEXT,
    S_SIGN,
    S_CONV,
    S_DIGIT
  } state_t;

  state_t                 state_r, state_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [2:0]             step_r, step_nxt;
  logic [SEG_IDX_W-1:0]   idx_r, idx_nxt;
  logic [15:0]            val_r, val_nxt;
  logic [DIG_IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [3:0]             dbuf_r [MAX_DIGITS];
  logic [3:0]             dbuf_nxt [MAX_DIGITS];
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_word_r, out_word_nxt;

  seg_t                   seg;
  logic [2:0]             step_inc;
  logic [15:0]            val_sel;
  logic                   can_emit;
  logic [31:0]            prod;
  logic [15:0]            quo;
  logic [15:0]            quo10;
  logic [3:0]             rem;
  logic [DIG_IDX_W-1:0]   dig_idx;
  logic [6:0]             txt_char;

  assign cmd_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign can_emit  = !out_valid_r || out_ready;
  assign step_inc  = 3'(step_r + 3'd1);
  assign dig_idx   = DIG_IDX_W'(cnt_r - DIG_IDX_W'(1));
  assign prod      = {16'd0, val_r} * {16'd0, DIV10_MUL};
  assign quo       = 16'(prod >> DIV10_SHIFT);
  assign quo10     = 16'({quo[12:0], 3'b000} + {quo[14:0], 1'b0});
  assign rem       = 4'(val_r - quo10);
  assign txt_char  = seg_char(seg, idx_r);

  always_comb begin
    if (cmd_r.fail) begin
      seg = SEG_FAIL;
    end else begin
      unique case (step_r)
        3'd0:    seg = SEG_HDR;
        3'd2:    seg = SEG_SEP_H;
        3'd4:    seg = SEG_SEP_L;
        default: seg = SEG_TAIL;
      endcase
    end
  end

  always_comb begin
    unique case (step_inc)
      3'd1:    val_sel = cmd_r.temp_mag;
      3'd3:    val_sel = {8'd0, cmd_r.humidity};
      default: val_sel = cmd_r.light_level;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    dbuf_nxt      = dbuf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_word_nxt  = out_word_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt   = cmd;
          step_nxt  = 3'd0;
          idx_nxt   = '0;
          state_nxt = S_TEXT;
        end
      end
      S_TEXT: begin
        if (can_emit) begin
          out_valid_nxt          = 1'b1;
          out_word_nxt.text_char = txt_char;
          out_word_nxt.frame_end = (txt_char == CH_NL);
          if (idx_r == seg_last(seg)) begin
            idx_nxt = '0;
            if (seg == SEG_TAIL || seg == SEG_FAIL) begin
              state_nxt = S_IDLE;
            end else begin
              step_nxt  = step_inc;
              val_nxt   = val_sel;
              cnt_nxt   = '0;
              state_nxt = (step_r == 3'd0 && cmd_r.neg) ? S_SIGN : S_CONV;
            end
          end else begin
            idx_nxt = SEG_IDX_W'(idx_r + SEG_IDX_W'(1));
          end
        end
      end
      S_SIGN: begin
        if (can_emit) begin
          out_valid_nxt          = 1'b1;
          out_word_nxt.text_char = CH_MINUS;
          out_word_nxt.frame_end = 1'b0;
          state_nxt              = S_CONV;
        end
      end
      S_CONV: begin
        dbuf_nxt[cnt_r] = rem;
        cnt_nxt         = DIG_IDX_W'(cnt_r + DIG_IDX_W'(1));
        val_nxt         = quo;
        if (quo == 16'd0 || cnt_r == DIG_IDX_W'(MAX_DIGITS - 1)) begin
          state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (can_emit) begin
          out_valid_nxt          = 1'b1;
          out_word_nxt.text_char = 7'(CH_ZERO + {3'b000, dbuf_r[dig_idx]});
          out_word_nxt.frame_end = 1'b0;
          cnt_nxt                = dig_idx;
          if (cnt_r == DIG_IDX_W'(1)) begin
            step_nxt  = step_inc;
            idx_nxt   = '0;
            state_nxt = S_TEXT;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    cmd_r      <= cmd_nxt;
    step_r     <= step_nxt;
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    dbuf_r     <= dbuf_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

### bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ssaf_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT_WORD = 2500;
  localparam int RANDOM_ITEMS = 450;
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FAILED = 1'b1;

  class frame_scoreboard;
    out_word_t pending_chars[$];
    int        mismatches;

    function void put_char(logic [6:0] c);
      out_word_t w;
      w.text_char = c;
      w.frame_end = (c == 7'h0A);
      pending_chars.push_back(w);
    endfunction

    function void put_text(string s);
      for (int i = 0; i < s.len(); i++) put_char(7'(s[i]));
    endfunction

    function void put_number(logic [15:0] v);
      logic [3:0] digits[5];
      int         n;
      n = 0;
      do begin
        digits[n] = 4'(v % 10);
        n++;
        v = v / 10;
      end while (v != 0 && n < 5);
      while (n > 0) begin
        n--;
        put_char(7'("0") + 7'(digits[n]));
      end
    endfunction

    function void note_record(in_word_t w);
      logic [15:0] mag;
      if (w.kind == KIND_FAILED) begin
        put_text("<F>\n");
        return;
      end
      put_text("<S,T=");
      if (w.temperature[15]) begin
        put_char(7'("-"));
        mag = 16'h0000 - 16'(w.temperature);
      end else begin
        mag = 16'(w.temperature);
      end
      put_number(mag);
      put_text(",H=");
      put_number(16'(w.humidity));
      put_text(",L=");
      put_number(w.light_level);
      put_text(">\n");
    endfunction

    function void report(string what, out_word_t want, out_word_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected char %h end %b, got char %h end %b", $time, what,
                 want.text_char, want.frame_end, got.text_char, got.frame_end);
    endfunction

    function void check_char(out_word_t got);
      out_word_t want;
      if (pending_chars.size() == 0) begin
        want = '0;
        report("unexpected character", want, got);
        return;
      end
      want = pending_chars.pop_front();
      if (got.text_char !== want.text_char) report("text_char mismatch", want, got);
      if (got.frame_end !== want.frame_end) report("frame_end mismatch", want, got);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  frame_scoreboard book = new();
  int  words_out = 0;
  int  cycles = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;

  sensor_sample_ascii_framer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) book.note_record(in_word);
    if (rst_n && out_valid && out_ready) begin
      book.check_char(out_word);
      words_out <= words_out + 1;
    end
  end

  function automatic in_word_t make_record(logic kind, logic [15:0] temp, logic [7:0] hum,
                                           logic [15:0] lux);
    in_word_t w;
    w.kind        = kind;
    w.temperature = temp;
    w.humidity    = hum;
    w.light_level = lux;
    return w;
  endfunction

  function automatic in_word_t random_record();
    in_word_t w;
    logic signed [15:0] t;
    t = 16'($urandom);
    w.kind        = ($urandom_range(0, 9) == 0) ? KIND_FAILED : KIND_SAMPLE;
    w.temperature = t >>> $urandom_range(0, 15);
    w.humidity    = 8'($urandom) >> $urandom_range(0, 8);
    w.light_level = 16'($urandom) >> $urandom_range(0, 16);
    return w;
  endfunction

  task automatic send_record(input in_word_t w);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin : receiver
    int gap;
    bit held;
    held = 1'b0;
    forever begin
      if (words_out % 200 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      gap = rx_steady ? 0 : $urandom_range(0, 16);
      if (!held && words_out >= HOLD_AT_WORD) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    in_word_t directed[$];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    directed.push_back(make_record(KIND_FAILED, 16'h1234, 8'h56, 16'h789A));
    directed.push_back(make_record(KIND_FAILED, 16'hFFFF, 8'hFF, 16'hFFFF));
    directed.push_back(make_record(KIND_SAMPLE, 16'd0, 8'd0, 16'd0));
    directed.push_back(make_record(KIND_SAMPLE, 16'h7FFF, 8'hFF, 16'hFFFF));
    directed.push_back(make_record(KIND_SAMPLE, 16'h8000, 8'd1, 16'd1));
    directed.push_back(make_record(KIND_SAMPLE, 16'h8001, 8'd9, 16'd9));
    directed.push_back(make_record(KIND_SAMPLE, 16'hFFFF, 8'd10, 16'd10));
    directed.push_back(make_record(KIND_SAMPLE, 16'd9, 8'd99, 16'd99));
    directed.push_back(make_record(KIND_SAMPLE, 16'd10, 8'd100, 16'd100));
    directed.push_back(make_record(KIND_SAMPLE, -16'sd10, 8'd199, 16'd999));
    directed.push_back(make_record(KIND_SAMPLE, -16'sd9999, 8'd200, 16'd9999));
    directed.push_back(make_record(KIND_SAMPLE, 16'd10000, 8'd128, 16'd10000));
    directed.push_back(make_record(KIND_SAMPLE, 16'd12345, 8'd42, 16'd54321));
    directed.push_back(make_record(KIND_SAMPLE, -16'sd100, 8'd0, 16'd65535));
    directed.push_back(make_record(KIND_FAILED, 16'h0000, 8'h00, 16'h0000));
    directed.push_back(make_record(KIND_SAMPLE, 16'd1, 8'd255, 16'd0));

    foreach (directed[i]) send_record(directed[i]);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) tx_steady = ($urandom_range(0, 2) == 0);
      send_record(random_record());
    end
    in_valid <= 1'b0;
    @(posedge clk);

    while (book.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.mismatches == 0 && book.pending_chars.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hdl/ssaf_pkg.sv
hdl/ssaf_front.sv
hdl/ssaf_back.sv
hdl/sensor_sample_ascii_framer.sv
bench/testbench.sv
